FILE: rtl/b2d_pkg.sv
// Shared types and constants for the binary to decimal digit converter.
package b2d_pkg;

  localparam int unsigned MaxDigitsDef = 10;
  localparam int unsigned ValW         = 32;
  localparam int unsigned MagW         = ValW + 1;
  localparam int unsigned DigitW       = 4;
  localparam int unsigned CntW         = $clog2(MagW);
  localparam int unsigned OutDataW     = ((DigitW + 7) / 8) * 8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_SCAN,
    ST_EMIT
  } b2d_state_e;

  typedef struct packed {
    logic load;
    logic shift;
    logic scan;
    logic emit;
  } b2d_cmd_t;

  typedef struct packed {
    logic conv_done;
    logic top_found;
    logic idx_zero;
    logic out_free;
  } b2d_sts_t;

endpackage

FILE: rtl/b2d_ctrl.sv
// Sequencer for the converter: load, shift-add-3 passes, leading zero scan, digit output.
module b2d_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  b2d_pkg::b2d_sts_t sts_i,
  output b2d_pkg::b2d_cmd_t cmd_o
);
  import b2d_pkg::*;

  b2d_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_CONVERT;
      end
      ST_CONVERT: begin
        if (sts_i.conv_done) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts_i.top_found) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free && sts_i.idx_zero) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_CONVERT: begin
        cmd_o.shift = 1'b1;
      end
      ST_SCAN: begin
        cmd_o.scan = !sts_i.top_found;
      end
      ST_EMIT: begin
        cmd_o.emit = sts_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

FILE: rtl/b2d_dp.sv
// Datapath: magnitude, BCD shift register, counters and the output register.
module b2d_dp #(
  parameter int unsigned MAX_DIGITS = b2d_pkg::MaxDigitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [b2d_pkg::ValW-1:0]      value_i,
  input  b2d_pkg::b2d_cmd_t             cmd_i,
  output b2d_pkg::b2d_sts_t             sts_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [b2d_pkg::DigitW-1:0]    out_digit_o,
  output logic                          out_last_o
);
  import b2d_pkg::*;

  localparam int unsigned IdxW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  logic [MagW-1:0]   mag_q, mag_d;
  logic [DigitW-1:0] dig_q [MAX_DIGITS];
  logic [DigitW-1:0] dig_d [MAX_DIGITS];
  logic [DigitW-1:0] adj   [MAX_DIGITS];
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [DigitW-1:0] sel_digit;
  logic [MagW-1:0]   ext_val;
  logic              out_valid_q, out_valid_d;
  logic [DigitW-1:0] out_digit_q, out_digit_d;
  logic              out_last_q, out_last_d;

  assign ext_val = {value_i[ValW-1], value_i};

  // Each digit is corrected before the shift so that doubling carries in decimal.
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      adj[i] = (dig_q[i] >= DigitW'(5)) ? dig_q[i] + DigitW'(3) : dig_q[i];
    end
  end

  always_comb begin
    sel_digit = '0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (idx_q == IdxW'(i)) sel_digit = dig_q[i];
    end
  end

  always_comb begin
    mag_d = mag_q;
    cnt_d = cnt_q;
    idx_d = idx_q;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      dig_d[i] = dig_q[i];
    end
    if (cmd_i.load) begin
      mag_d = ext_val[MagW-1] ? (~ext_val + MagW'(1)) : ext_val;
      cnt_d = CntW'(MagW - 1);
      idx_d = IdxW'(MAX_DIGITS - 1);
      for (int i = 0; i < MAX_DIGITS; i++) begin
        dig_d[i] = '0;
      end
    end else if (cmd_i.shift) begin
      // The carry out of the top digit is dropped, which keeps the value modulo 10^N.
      dig_d[0] = {adj[0][DigitW-2:0], mag_q[MagW-1]};
      for (int i = 1; i < MAX_DIGITS; i++) begin
        dig_d[i] = {adj[i][DigitW-2:0], adj[i-1][DigitW-1]};
      end
      mag_d = {mag_q[MagW-2:0], 1'b0};
      cnt_d = cnt_q - CntW'(1);
    end else if (cmd_i.scan || cmd_i.emit) begin
      if (idx_q != '0) idx_d = idx_q - IdxW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    cnt_q <= cnt_d;
    idx_q <= idx_d;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      dig_q[i] <= dig_d[i];
    end
    out_digit_q <= out_digit_d;
    out_last_q  <= out_last_d;
  end

  always_comb begin
    out_digit_d = out_digit_q;
    out_last_d  = out_last_q;
    out_valid_d = out_valid_q;
    if (cmd_i.emit) begin
      out_digit_d = sel_digit;
      out_last_d  = (idx_q == '0);
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign sts_o.conv_done = (cnt_q == '0);
  assign sts_o.top_found = (sel_digit != '0) || (idx_q == '0);
  assign sts_o.idx_zero  = (idx_q == '0);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_digit_o = out_digit_q;
  assign out_last_o  = out_last_q;

endmodule

FILE: rtl/binary_to_decimal_digits.sv
// Top level of the binary to decimal digit converter.
//
// Slave channel: one beat carries a signed 32-bit value. Master channel: one
// beat per decimal digit of its magnitude, most significant first, without
// leading zeros; tlast marks the least significant digit. Zero gives a single
// digit 0. Only the MAX_DIGITS least significant digits of the magnitude are
// kept. The block handles one value at a time.
// After an input beat is accepted, the shift-add-3 sequence makes one pass
// per magnitude bit, followed by a leading zero scan from the top digit
// position down to the first nonzero digit. Digits then leave at one per
// cycle from the output register while the receiver is ready. The slave
// channel is ready again as soon as the last digit is loaded, even while
// that digit still waits for the receiver.
// When the receiver stalls, the output register holds its beat and the
// sequencer waits. Reset empties the output register and returns to idle.
module binary_to_decimal_digits #(
  parameter int unsigned MAX_DIGITS = b2d_pkg::MaxDigitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [b2d_pkg::ValW-1:0]       s_axis_tdata_i,  // [31:0] value
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [b2d_pkg::OutDataW-1:0]   m_axis_tdata_o,  // [3:0] digit, rest zero
  output logic                           m_axis_tlast_o   // last_digit
);
  import b2d_pkg::*;

  b2d_cmd_t          cmd;
  b2d_sts_t          sts;
  logic [DigitW-1:0] digit;

  b2d_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  b2d_dp #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (s_axis_tdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_digit_o (digit),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = OutDataW'(digit);

endmodule

FILE: rtl/b2d_checker.sv
// Port-level checks for the converter, bound to the top level.
module b2d_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid_i,
  input logic                         s_axis_tready_o,
  input logic                         m_axis_tvalid_o,
  input logic                         m_axis_tready_i,
  input logic [b2d_pkg::OutDataW-1:0] m_axis_tdata_o,
  input logic                         m_axis_tlast_o
);
  import b2d_pkg::*;

  // Every beat carries a decimal digit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o <= OutDataW'(9)))
    else $error("digit out of decimal range");

  // While the block is ready for a new value, only a final digit may be pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tready_o && m_axis_tvalid_o) |-> m_axis_tlast_o)
    else $error("new value taken while a run is unfinished");

  // A value just taken keeps the block busy at the start of its conversion.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o ##1 !s_axis_tready_o)
    else $error("ready returned during conversion");

  // A stalled beat holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o)))
    else $error("stalled beat changed");

endmodule

bind binary_to_decimal_digits b2d_checker u_b2d_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

FILE: test/tb.sv
// Self-checking testbench for the binary to decimal digit converter.
`timescale 1ns / 100ps

module tb;
  import b2d_pkg::*;

  localparam int unsigned MaxDigits  = MaxDigitsDef;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned TailCycles = 3 * (35 + MaxDigits);
  localparam int unsigned RandPerPhase = 130;

  typedef struct {
    logic [DigitW-1:0] digit;
    logic              last;
  } digit_beat_t;

  typedef struct {
    logic [ValW-1:0] value;
    string           digits;  // empty: predicted, not typed in
  } value_row_t;

  localparam int unsigned NumRows = 24;

  value_row_t value_rows [NumRows] = '{
    '{32'd0,                    "0"},
    '{32'd1,                    "1"},
    '{32'hFFFF_FFFF,            "1"},
    '{32'd9,                    "9"},
    '{32'd10,                   "10"},
    '{-32'd10,                  "10"},
    '{32'd99,                   "99"},
    '{32'd100,                  "100"},
    '{32'h7FFF_FFFF,            "2147483647"},
    '{32'h8000_0000,            "2147483648"},
    '{32'h8000_0001,            "2147483647"},
    '{32'd1000000000,           "1000000000"},
    '{-32'd1000000000,          "1000000000"},
    '{32'd999999999,            "999999999"},
    '{32'h5555_5555,            ""},
    '{32'hAAAA_AAAA,            ""},
    '{32'h0F0F_0F0F,            ""},
    '{32'hF0F0_F0F0,            ""},
    '{32'd1234567890,           ""},
    '{-32'd1234567890,          ""},
    '{32'd1000000001,           ""},
    '{32'd90000009,             ""},
    '{32'd100000,               ""},
    '{-32'd12345,               ""}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [ValW-1:0]     s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;

  digit_beat_t digit_due_q [$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned quiet_cycles = 0;

  binary_to_decimal_digits #(
    .MAX_DIGITS(MaxDigits)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),
    .m_axis_tlast_o (m_axis_tlast)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Appends one owed beat at the tail of the scoreboard queue.
  function automatic void queue_digit(input digit_beat_t beat);
    digit_due_q = {digit_due_q, beat};
  endfunction

  // Queues the digits of the magnitude that fit the digit register,
  // most significant first, without leading zeros.
  function automatic void push_decimal_digits(input logic [ValW-1:0] value);
    logic [MagW-1:0]   mag;
    logic [DigitW-1:0] dig [MaxDigits];
    digit_beat_t       beat;
    int                top;
    mag = value[ValW-1] ? ({1'b1, {ValW{1'b0}}} - {1'b0, value}) : {1'b0, value};
    for (int i = 0; i < MaxDigits; i++) begin
      dig[i] = DigitW'(mag % 10);
      mag = mag / 10;
    end
    top = 0;
    for (int i = MaxDigits - 1; i > 0; i--) begin
      if (top == 0 && dig[i] != 0) begin
        top = i;
      end
    end
    for (int i = top; i >= 0; i--) begin
      beat.digit = dig[i];
      beat.last  = (i == 0);
      queue_digit(beat);
    end
  endfunction

  // Offers one value, waits for its beat, then queues the digits it owes.
  task automatic send_value(input logic [ValW-1:0] value, input string digits);
    digit_beat_t beat;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    do @(posedge clk_i); while (!s_axis_tready);
    if (digits.len() == 0) begin
      push_decimal_digits(value);
    end else begin
      for (int k = 0; k < digits.len(); k++) begin
        beat.digit = DigitW'(digits[k] - "0");
        beat.last  = (k == digits.len() - 1);
        queue_digit(beat);
      end
    end
  endtask

  // Mixes full-range values with values of every digit count and values
  // next to powers of ten, where carries ripple through all digits.
  task automatic send_random(input int unsigned count);
    logic [ValW-1:0] value;
    logic [ValW-1:0] ten_pow;
    for (int n = 0; n < count; n++) begin
      ten_pow = 1;
      repeat ($urandom_range(1, 9)) ten_pow = ten_pow * 10;
      case ($urandom_range(0, 3))
        0: value = $urandom;
        1: value = $urandom_range(0, 99);
        2: value = $urandom % ten_pow;
        default: value = ten_pow + $urandom_range(0, 2) - 1;
      endcase
      if ($urandom_range(0, 1) == 1) begin
        value = -value;
      end
      send_value(value, "");
    end
  endtask

  // Holds the slave side quiet until every queued digit has left.
  task automatic drain_digits();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (digit_due_q.size() != 0);
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    digit_beat_t due;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (digit_due_q.size() == 0) begin
        $display("%0t: digit beat with nothing expected, got %0d last %0b",
                 $time, m_axis_tdata, m_axis_tlast);
        mismatch_cnt++;
      end else begin
        due = digit_due_q.pop_front();
        if (m_axis_tdata !== OutDataW'(due.digit)) begin
          $display("%0t: digit mismatch, expected %0d got %0d",
                   $time, due.digit, m_axis_tdata);
          mismatch_cnt++;
        end
        if (m_axis_tlast !== due.last) begin
          $display("%0t: last digit mismatch, expected %0b got %0b",
                   $time, due.last, m_axis_tlast);
          mismatch_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == StallLimit) begin
      $display("%0t: no beat for %0d cycles", $time, StallLimit);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 24;
    recv_idle_pct = 50;
    for (int r = 0; r < NumRows; r++) begin
      send_value(value_rows[r].value, value_rows[r].digits);
    end
    send_random(RandPerPhase);
    drain_digits();

    send_idle_pct = 50;
    recv_idle_pct = 24;
    send_random(RandPerPhase);
    drain_digits();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(RandPerPhase);
    drain_digits();

    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/b2d_pkg.sv
rtl/b2d_ctrl.sv
rtl/b2d_dp.sv
rtl/binary_to_decimal_digits.sv
rtl/b2d_checker.sv
test/tb.sv
